[hw/rtl/fractal_value_noise_2d_top_macros.svh]
// Assertion macros for the fractal value noise block.
// Included by fractal_value_noise_2d_top.sv; no other dependencies.
`ifndef FRACTAL_VALUE_NOISE_2D_TOP_MACROS_SVH
`define FRACTAL_VALUE_NOISE_2D_TOP_MACROS_SVH

// same-cycle implication
`define FVN2D_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fvn2d: same-cycle check failed");

// next-cycle implication
`define FVN2D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fvn2d: next-cycle check failed");

`endif

[hw/rtl/fvn2d_pkg.sv]
// Shared constants, register codes and the inter-cell beat type for fractal value noise.
// No dependencies.
package fvn2d_pkg;

   localparam int MAX_OCTAVES = 4;
   localparam int CNT_W       = $clog2(MAX_OCTAVES + 1);

   localparam int COORD_W    = 32;
   localparam int SEED_W     = 32;
   localparam int FREQ_W     = 16;
   localparam int CFG_OCT_W  = 3;
   localparam int NOISE_W    = 18;
   localparam int CORNER_W   = 18;
   localparam int FRAC_BITS  = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int PROD_W = COORD_W + FREQ_W;
   localparam int PX_W   = PROD_W + MAX_OCTAVES - 1;
   localparam int ACC_W  = NOISE_W + MAX_OCTAVES;

   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   localparam logic [SEED_W-1:0]    SEED_BASE_RST    = 32'd7;
   localparam logic [FREQ_W-1:0]    BASE_FREQ_RST    = 16'd2294;
   localparam logic [CFG_OCT_W-1:0] OCTAVE_COUNT_RST = 3'd4;

   localparam logic [31:0] HASH_MX = 32'd374761393;
   localparam logic [31:0] HASH_MZ = 32'd668265263;
   localparam logic [31:0] HASH_MS = 32'd2246822519;
   localparam logic [31:0] HASH_MF = 32'd1274126177;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED_BASE    = 2'd0,
      CSR_BASE_FREQ    = 2'd1,
      CSR_OCTAVE_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                     valid;
      logic [CNT_W-1:0]         octs;
      logic [CNT_W-1:0]         left;
      logic [SEED_W-1:0]        seed;
      logic signed [PX_W-1:0]   px;
      logic signed [PX_W-1:0]   pz;
      logic signed [ACC_W-1:0]  acc;
   } oct_beat_type;

endpackage

[hw/rtl/fractal_value_noise_2d_top.sv]
// Top level of the fractal value noise block: CSRs, input stage, octave cell chain, normaliser.
// Depends on fvn2d_pkg, fvn2d_octave_cell, fvn2d_normaliser, fractal_value_noise_2d_top_macros.svh.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_x_coord, req_z_coord (Q16.16)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_noise_value (Q1.16)
//  csr     | in        | csr_write_en         | csr_index, csr_wdata
//
// One beat per cycle sustained while req_stall is low; every result, whatever the octave count,
// passes the same registers after its input beat is taken: the input register loads on the
// accepting edge, then eight stages per octave cell, then the scaling and output registers.
// Synchronous reset clears all valid bits and restores the CSR defaults.
// The output register and the scaling stage both hold a result before the chain freezes,
// so input beats are still taken while one result waits on rsp_stall.
`include "fractal_value_noise_2d_top_macros.svh"

module fractal_value_noise_2d_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [fvn2d_pkg::COORD_W-1:0]     req_x_coord,
   input  logic signed [fvn2d_pkg::COORD_W-1:0]     req_z_coord,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [fvn2d_pkg::NOISE_W-1:0]     rsp_noise_value,
   input  logic                                     csr_write_en,
   input  logic [fvn2d_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [fvn2d_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   logic [fvn2d_pkg::SEED_W-1:0]    seed_base_ff;
   logic [fvn2d_pkg::FREQ_W-1:0]    base_freq_ff;
   logic [fvn2d_pkg::CFG_OCT_W-1:0] octave_count_ff;

   logic [fvn2d_pkg::CNT_W-1:0]          octs_eff;
   logic signed [fvn2d_pkg::PROD_W-1:0]  px_prod, pz_prod;
   fvn2d_pkg::oct_beat_type              in_beat_ff, in_beat_in;
   fvn2d_pkg::oct_beat_type              chain [fvn2d_pkg::MAX_OCTAVES + 1];
   logic                                 adv;
   logic                                 norm_busy;
   logic                                 rsp_in_range;
   logic                                 in_octs_legal;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_base_ff    <= fvn2d_pkg::SEED_BASE_RST;
         base_freq_ff    <= fvn2d_pkg::BASE_FREQ_RST;
         octave_count_ff <= fvn2d_pkg::OCTAVE_COUNT_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            fvn2d_pkg::CSR_SEED_BASE: begin
               seed_base_ff <= csr_wdata[fvn2d_pkg::SEED_W-1:0];
            end
            fvn2d_pkg::CSR_BASE_FREQ: begin
               base_freq_ff <= csr_wdata[fvn2d_pkg::FREQ_W-1:0];
            end
            fvn2d_pkg::CSR_OCTAVE_COUNT: begin
               octave_count_ff <= csr_wdata[fvn2d_pkg::CFG_OCT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (octave_count_ff == '0) begin
         octs_eff = fvn2d_pkg::CNT_W'(1);
      end else if (int'(octave_count_ff) > fvn2d_pkg::MAX_OCTAVES) begin
         octs_eff = fvn2d_pkg::CNT_W'(fvn2d_pkg::MAX_OCTAVES);
      end else begin
         octs_eff = fvn2d_pkg::CNT_W'(octave_count_ff);
      end
   end

   assign px_prod = req_x_coord * $signed({1'b0, base_freq_ff});
   assign pz_prod = req_z_coord * $signed({1'b0, base_freq_ff});

   always_comb begin
      in_beat_in.valid = req_valid;
      in_beat_in.octs  = octs_eff;
      in_beat_in.left  = octs_eff;
      in_beat_in.seed  = seed_base_ff;
      in_beat_in.px    = fvn2d_pkg::PX_W'(px_prod);
      in_beat_in.pz    = fvn2d_pkg::PX_W'(pz_prod);
      in_beat_in.acc   = '0;
   end

   // chain freezes only when scaling stage and output register are both full and held
   assign adv       = !(norm_busy && rsp_valid && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_beat_ff <= '0;
      end else if (adv) begin
         in_beat_ff <= in_beat_in;
      end
   end

   assign chain[0] = in_beat_ff;

   for (genvar gk = 0; gk < fvn2d_pkg::MAX_OCTAVES; gk++) begin : g_cell
      fvn2d_octave_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .beat_in  (chain[gk]),
         .beat_out (chain[gk+1])
      );
   end

   fvn2d_normaliser u_norm (
      .clock           (clock),
      .reset           (reset),
      .en              (adv),
      .beat_in         (chain[fvn2d_pkg::MAX_OCTAVES]),
      .rsp_stall       (rsp_stall),
      .stage_valid     (norm_busy),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value)
   );

   assign rsp_in_range  = (rsp_noise_value <= 18'sd65536) && (rsp_noise_value >= -18'sd65536);
   assign in_octs_legal = (in_beat_ff.octs != '0)
                       && (int'(in_beat_ff.octs) <= fvn2d_pkg::MAX_OCTAVES);

   `FVN2D_ASSERT_NOW(a_out_range, clock, reset, rsp_valid, rsp_in_range)
   `FVN2D_ASSERT_NEXT(a_accept_loads, clock, reset, req_valid && !req_stall, in_beat_ff.valid)
   `FVN2D_ASSERT_NEXT(a_frozen_holds, clock, reset, req_stall, $stable(in_beat_ff))
   `FVN2D_ASSERT_NOW(a_octs_legal, clock, reset, in_beat_ff.valid, in_octs_legal)

endmodule

[hw/rtl/fvn2d_octave_cell.sv]
// One octave cell: lattice hash, fade, bilinear blend, Horner accumulate, eight stages.
// Depends on fvn2d_pkg.
module fvn2d_octave_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  fvn2d_pkg::oct_beat_type beat_in,
   output fvn2d_pkg::oct_beat_type beat_out
);

   localparam int LINE_D = 7;
   localparam int CW     = fvn2d_pkg::CORNER_W;
   localparam int DIFF_W = CW + 1;
   localparam int FADE_W = fvn2d_pkg::FRAC_BITS + 1;
   localparam int BLD_W  = DIFF_W + FADE_W + 1;
   localparam int NUM_W  = 50;
   localparam logic [17:0]       FADE_K3    = 18'd196608;
   localparam logic [NUM_W:0]    FADE_HALF  = (NUM_W + 1)'(64'd1 << 31);
   localparam logic signed [BLD_W-1:0] BLEND_HALF = BLD_W'(32768);
   localparam logic signed [CW-1:0]    CORNER_OFS = CW'(65536);

   function automatic logic signed [CW-1:0] corner_value(input logic [31:0] g);
      logic [31:0] h;
      h = g ^ (g >> 16);
      return $signed({1'b0, h[15:0], 1'b0}) - CORNER_OFS;
   endfunction

   // carried beat
   fvn2d_pkg::oct_beat_type line_ff [LINE_D];
   fvn2d_pkg::oct_beat_type beat_out_ff, beat_out_in;

   // stage 1
   logic [63:0] px_ext, pz_ext;
   logic [31:0] cx, cz;
   logic [15:0] fx, fz;
   logic [31:0] ax_ff, az_ff, as_ff, ax_in, az_in, as_in;
   logic [31:0] ffx_ff, ffz_ff, ffx_in, ffz_in;
   logic [17:0] tx_ff, tz_ff, tx_in, tz_in;
   // stage 2
   logic [31:0] base;
   logic [31:0] pre_ff [4];
   logic [31:0] pre_in [4];
   logic [NUM_W-1:0] numx_ff, numz_ff, numx_in, numz_in;
   // stage 3
   logic [31:0] g_ff [4];
   logic [31:0] g_in [4];
   logic [NUM_W:0] rndx, rndz;
   logic [FADE_W-1:0] sx_ff, sz_ff, sx_in, sz_in;
   // stage 4
   logic signed [CW-1:0] v_ff [4];
   logic signed [CW-1:0] v_in [4];
   logic [FADE_W-1:0] sx2_ff, sz2_ff, sz3_ff, sz4_ff;
   // stage 5
   logic signed [DIFF_W-1:0] diff_top, diff_bot;
   logic signed [BLD_W-1:0] dtop_ff, dbot_ff, dtop_in, dbot_in;
   logic signed [CW-1:0] atop_ff, abot_ff;
   // stage 6
   logic signed [BLD_W-1:0] rtop, rbot;
   logic signed [CW-1:0] top_ff, bot_ff, top_in, bot_in;
   // stage 7
   logic signed [DIFF_W-1:0] diff_v;
   logic signed [BLD_W-1:0] dv_ff, dv_in;
   logic signed [CW-1:0] top2_ff;
   // stage 8
   logic signed [BLD_W-1:0] rv;
   logic signed [CW-1:0] oct_v;

   assign px_ext = 64'($signed(beat_in.px));
   assign pz_ext = 64'($signed(beat_in.pz));
   assign cx     = px_ext[63:32];
   assign cz     = pz_ext[63:32];
   assign fx     = beat_in.px[31:16];
   assign fz     = beat_in.pz[31:16];

   assign ax_in  = cx * fvn2d_pkg::HASH_MX;
   assign az_in  = cz * fvn2d_pkg::HASH_MZ;
   assign as_in  = beat_in.seed * fvn2d_pkg::HASH_MS;
   assign ffx_in = 32'(fx) * 32'(fx);
   assign ffz_in = 32'(fz) * 32'(fz);
   assign tx_in  = FADE_K3 - {1'b0, fx, 1'b0};
   assign tz_in  = FADE_K3 - {1'b0, fz, 1'b0};

   assign base      = ax_ff + az_ff + as_ff;
   assign pre_in[0] = base;
   assign pre_in[1] = base + fvn2d_pkg::HASH_MX;
   assign pre_in[2] = base + fvn2d_pkg::HASH_MZ;
   assign pre_in[3] = base + fvn2d_pkg::HASH_MX + fvn2d_pkg::HASH_MZ;
   assign numx_in   = NUM_W'(ffx_ff) * NUM_W'(tx_ff);
   assign numz_in   = NUM_W'(ffz_ff) * NUM_W'(tz_ff);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         g_in[i] = (pre_ff[i] ^ (pre_ff[i] >> 13)) * fvn2d_pkg::HASH_MF;
         v_in[i] = corner_value(g_ff[i]);
      end
   end

   assign rndx  = (NUM_W + 1)'(numx_ff) + FADE_HALF;
   assign rndz  = (NUM_W + 1)'(numz_ff) + FADE_HALF;
   assign sx_in = rndx[FADE_W+31:32];
   assign sz_in = rndz[FADE_W+31:32];

   assign diff_top = DIFF_W'(v_ff[1]) - DIFF_W'(v_ff[0]);
   assign diff_bot = DIFF_W'(v_ff[3]) - DIFF_W'(v_ff[2]);
   assign dtop_in  = BLD_W'(diff_top) * BLD_W'($signed({1'b0, sx2_ff}));
   assign dbot_in  = BLD_W'(diff_bot) * BLD_W'($signed({1'b0, sx2_ff}));

   assign rtop   = (dtop_ff + BLEND_HALF) >>> fvn2d_pkg::FRAC_BITS;
   assign rbot   = (dbot_ff + BLEND_HALF) >>> fvn2d_pkg::FRAC_BITS;
   assign top_in = atop_ff + CW'(rtop);
   assign bot_in = abot_ff + CW'(rbot);

   assign diff_v = DIFF_W'(bot_ff) - DIFF_W'(top_ff);
   assign dv_in  = BLD_W'(diff_v) * BLD_W'($signed({1'b0, sz4_ff}));

   assign rv    = (dv_ff + BLEND_HALF) >>> fvn2d_pkg::FRAC_BITS;
   assign oct_v = top2_ff + CW'(rv);

   always_comb begin
      beat_out_in      = line_ff[LINE_D-1];
      beat_out_in.px   = line_ff[LINE_D-1].px <<< 1;
      beat_out_in.pz   = line_ff[LINE_D-1].pz <<< 1;
      beat_out_in.seed = line_ff[LINE_D-1].seed + 1'b1;
      if (line_ff[LINE_D-1].left != '0) begin
         beat_out_in.left = line_ff[LINE_D-1].left - 1'b1;
         beat_out_in.acc  = (line_ff[LINE_D-1].acc <<< 1) + fvn2d_pkg::ACC_W'(oct_v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_D; i++) begin
            line_ff[i] <= '0;
         end
         beat_out_ff <= '0;
      end else if (en) begin
         line_ff[0] <= beat_in;
         for (int i = 1; i < LINE_D; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
         beat_out_ff <= beat_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff   <= ax_in;
         az_ff   <= az_in;
         as_ff   <= as_in;
         ffx_ff  <= ffx_in;
         ffz_ff  <= ffz_in;
         tx_ff   <= tx_in;
         tz_ff   <= tz_in;
         pre_ff  <= pre_in;
         numx_ff <= numx_in;
         numz_ff <= numz_in;
         g_ff    <= g_in;
         sx_ff   <= sx_in;
         sz_ff   <= sz_in;
         v_ff    <= v_in;
         sx2_ff  <= sx_ff;
         sz2_ff  <= sz_ff;
         dtop_ff <= dtop_in;
         dbot_ff <= dbot_in;
         atop_ff <= v_ff[0];
         abot_ff <= v_ff[2];
         sz3_ff  <= sz2_ff;
         top_ff  <= top_in;
         bot_ff  <= bot_in;
         sz4_ff  <= sz3_ff;
         dv_ff   <= dv_in;
         top2_ff <= top_ff;
      end
   end

   assign beat_out = beat_out_ff;

endmodule

[hw/rtl/fvn2d_normaliser.sv]
// Normaliser: scales the weighted octave sum by the reciprocal weight total, saturates,
// and holds the result in the output register. Depends on fvn2d_pkg.
module fvn2d_normaliser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  fvn2d_pkg::oct_beat_type               beat_in,
   input  logic                                  rsp_stall,
   output logic                                  stage_valid,
   output logic                                  rsp_valid,
   output logic signed [fvn2d_pkg::NOISE_W-1:0]  rsp_noise_value
);

   localparam int NPROD_W = fvn2d_pkg::ACC_W + fvn2d_pkg::RECIP_W + 1;
   localparam logic signed [NPROD_W-1:0] NORM_HALF =
      NPROD_W'(64'd1 << (fvn2d_pkg::RECIP_SHIFT - 1));
   localparam logic signed [NPROD_W-1:0] NOISE_MAX = NPROD_W'(65536);
   localparam logic signed [NPROD_W-1:0] NOISE_MIN = -NOISE_MAX;

   logic [fvn2d_pkg::RECIP_W-1:0] recip_tab [fvn2d_pkg::MAX_OCTAVES + 1];

   assign recip_tab[0] = '0;
   for (genvar gi = 1; gi <= fvn2d_pkg::MAX_OCTAVES; gi++) begin : g_recip
      localparam longint unsigned TOTAL = (64'd1 << gi) - 64'd1;
      localparam logic [fvn2d_pkg::RECIP_W-1:0] RECIP = fvn2d_pkg::RECIP_W'(
         ((64'd1 << fvn2d_pkg::RECIP_SHIFT) + TOTAL / 2) / TOTAL);
      assign recip_tab[gi] = RECIP;
   end

   logic                        n1_valid_ff;
   logic signed [NPROD_W-1:0]   prod_ff, prod_in;
   logic signed [NPROD_W-1:0]   rnd;
   logic signed [fvn2d_pkg::NOISE_W-1:0] sat;
   logic                        out_load;
   logic                        rsp_valid_ff;
   logic signed [fvn2d_pkg::NOISE_W-1:0] rsp_value_ff;

   assign prod_in = NPROD_W'(beat_in.acc) * NPROD_W'($signed({1'b0, recip_tab[beat_in.octs]}));
   assign rnd     = (prod_ff + NORM_HALF) >>> fvn2d_pkg::RECIP_SHIFT;

   always_comb begin
      if (rnd > NOISE_MAX) begin
         sat = fvn2d_pkg::NOISE_W'(NOISE_MAX);
      end else if (rnd < NOISE_MIN) begin
         sat = fvn2d_pkg::NOISE_W'(NOISE_MIN);
      end else begin
         sat = fvn2d_pkg::NOISE_W'(rnd);
      end
   end

   assign out_load = !(rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            n1_valid_ff <= beat_in.valid;
         end
         if (out_load) begin
            rsp_valid_ff <= n1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
      if (out_load) begin
         rsp_value_ff <= sat;
      end
   end

   assign stage_valid     = n1_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for fractal_value_noise_2d_top: random and edge-case points over
// several register settings, with each result checked against an in-bench noise predictor.
// Depends on fvn2d_pkg and the fractal_value_noise_2d_top RTL.
module testbench;
   import fvn2d_pkg::*;

   localparam int LIMIT_CYCLES  = 500000;
   localparam int SETTLE_CYCLES = 8 * MAX_OCTAVES + 3 + 10;
   localparam int HOLD_CYCLES   = 250;
   localparam int PHASE_ITEMS   = 117;
   localparam int PHASES        = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] z;
      logic signed [NOISE_W-1:0] noise;
   } noise_due_type;

   class noise_tracker_type;
      logic [SEED_W-1:0]    seed_base;
      logic [FREQ_W-1:0]    base_freq;
      logic [CFG_OCT_W-1:0] octave_count;
      noise_due_type        due[$];
      int                   errors;

      function new();
         seed_base    = SEED_BASE_RST;
         base_freq    = BASE_FREQ_RST;
         octave_count = OCTAVE_COUNT_RST;
         errors       = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_SEED_BASE:    seed_base    = data[SEED_W-1:0];
            CSR_BASE_FREQ:    base_freq    = data[FREQ_W-1:0];
            CSR_OCTAVE_COUNT: octave_count = data[CFG_OCT_W-1:0];
            default: ;
         endcase
      endfunction

      function longint corner_level(logic [31:0] cx, logic [31:0] cz, logic [31:0] seed);
         logic [31:0] h;
         h = cx * HASH_MX + cz * HASH_MZ + seed * HASH_MS;
         h = (h ^ (h >> 13)) * HASH_MF;
         h = h ^ (h >> 16);
         return 2 * longint'(h[15:0]) - 65536;
      endfunction

      function longint smoothstep(logic [15:0] f);
         logic [63:0] ff;
         logic [63:0] num;
         ff  = 64'(f) * 64'(f);
         num = ff * (64'd196608 - 2 * 64'(f));
         return longint'((num + 64'd2147483648) >> 32);
      endfunction

      function longint blend(longint a, longint b, longint t);
         longint d;
         d = (b - a) * t;
         return a + ((d + 32768) >>> 16);
      endfunction

      function logic signed [NOISE_W-1:0] fractal_noise(logic signed [COORD_W-1:0] x,
                                                       logic signed [COORD_W-1:0] z);
         logic signed [63:0] px, pz;
         logic [63:0]        shx, shz;
         logic [31:0]        cx, cz, seed;
         logic [15:0]        fx, fz;
         longint             sx, sz, upper, lower, sum, total, recip, scaled;
         int                 n, k;
         n = octave_count;
         if (n == 0) n = 1;
         if (n > MAX_OCTAVES) n = MAX_OCTAVES;
         px  = $signed({{32{x[31]}}, x}) * $signed({48'd0, base_freq});
         pz  = $signed({{32{z[31]}}, z}) * $signed({48'd0, base_freq});
         sum = 0;
         for (k = 0; k < n; k++) begin
            seed  = seed_base + 32'(k);
            cx    = 32'(px >>> (32 - k));
            cz    = 32'(pz >>> (32 - k));
            shx   = px << k;
            shz   = pz << k;
            fx    = shx[31:16];
            fz    = shz[31:16];
            sx    = smoothstep(fx);
            sz    = smoothstep(fz);
            upper = blend(corner_level(cx, cz, seed), corner_level(cx + 1, cz, seed), sx);
            lower = blend(corner_level(cx, cz + 1, seed),
                          corner_level(cx + 1, cz + 1, seed), sx);
            sum   = sum + (blend(upper, lower, sz) <<< (n - 1 - k));
         end
         total  = (longint'(1) << n) - 1;
         recip  = ((longint'(1) << RECIP_SHIFT) + total / 2) / total;
         scaled = (sum * recip + (longint'(1) << (RECIP_SHIFT - 1))) >>> RECIP_SHIFT;
         if (scaled > 65536) scaled = 65536;
         if (scaled < -65536) scaled = -65536;
         return NOISE_W'(scaled);
      endfunction

      function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] z);
         noise_due_type d;
         d.x     = x;
         d.z     = z;
         d.noise = fractal_noise(x, z);
         due.insert(due.size(), d);
      endfunction

      function int pending();
         return due.size();
      endfunction

      task report(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_noise(logic signed [NOISE_W-1:0] got);
         noise_due_type d;
         if (due.size() == 0) begin
            report($sformatf("noise beat %0d with nothing outstanding", got));
         end else begin
            d = due.pop_front();
            if (got !== d.noise)
               report($sformatf("noise for x=%h z=%h: got %0d, want %0d",
                                d.x, d.z, got, d.noise));
         end
      endtask
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [COORD_W-1:0]   req_x_coord = '0;
   logic signed [COORD_W-1:0]   req_z_coord = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [NOISE_W-1:0]   rsp_noise_value;
   logic                        csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   noise_tracker_type board;
   bit           tx_idle = 1'b1;
   bit           rx_idle = 1'b1;
   bit           hold_req = 1'b0;
   bit           hold_done = 1'b0;
   int           stall_left = 0;
   int           hold_left = 0;
   int           cycles = 0;

   logic [COORD_W-1:0] edge_points[12][2] = '{
      '{32'h00000000, 32'h00000000}, '{32'h7FFFFFFF, 32'h80000000},
      '{32'h80000000, 32'h7FFFFFFF}, '{32'hFFFFFFFF, 32'hFFFFFFFF},
      '{32'h7FFFFFFF, 32'h7FFFFFFF}, '{32'h80000000, 32'h80000000},
      '{32'h00010000, 32'hFFFF0000}, '{32'h0000FFFF, 32'hFFFF0001},
      '{32'h00008000, 32'h00008000}, '{32'hFFFF8000, 32'h00000001},
      '{32'h12345678, 32'h87654321}, '{32'h55555555, 32'hAAAAAAAA}
   };

   fractal_value_noise_2d_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_coord     (req_x_coord),
      .req_z_coord     (req_z_coord),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise_value (rsp_noise_value),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_point(req_x_coord, req_z_coord);
         if (rsp_valid && !rsp_stall) board.check_noise(rsp_noise_value);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("fractal_value_noise_2d_top test failed");
         $finish;
      end
   end

   // receiver: long hold on request, otherwise short random stall bursts while rx_idle is set
   always @(negedge clock) begin
      if (hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 3))
         0, 1:    return $urandom;
         2:       return 32'($urandom_range(0, 32'h00FFFFFF)) - 32'h00800000;
         default: return ($urandom & 32'hFFFF0000) | 32'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] z);
      int gap;
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_z_coord <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      int i;
      for (i = 0; i < count; i++) send_point(random_coord(), random_coord());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      board.write_register(index, data);
      @(negedge clock);
   endtask

   task automatic configure(input logic [SEED_W-1:0] seed, input logic [FREQ_W-1:0] freq,
                            input logic [CFG_OCT_W-1:0] octs);
      write_csr(CSR_SEED_BASE, seed);
      write_csr(CSR_BASE_FREQ, 32'(freq));
      write_csr(CSR_OCTAVE_COUNT, 32'(octs));
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int phase, i;
      board = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (edge_points[i]) send_point(edge_points[i][0], edge_points[i][1]);
      send_random(PHASE_ITEMS);
      for (phase = 1; phase < PHASES; phase++) begin
         drain();
         case (phase)
            1: configure(32'h00000000, 16'hFFFF, 3'd1);
            2: configure(32'hFFFFFFFF, 16'h0001, 3'd4);
            3: configure($urandom, 16'h0000, 3'd3);
            4: configure($urandom, 16'($urandom_range(1, 65535)), 3'd0);
            5: configure($urandom, 16'($urandom_range(1, 8000)), 3'd7);
            6: configure($urandom, 16'($urandom_range(1, 65535)), 3'd5);
            7: configure($urandom, 16'($urandom_range(1, 300)), 3'd2);
            8: begin
               write_csr(CSR_SPARE, $urandom);
               configure($urandom, 16'($urandom_range(1, 65535)), 3'd6);
            end
            default: configure($urandom, 16'($urandom_range(0, 65535)),
                               3'($urandom_range(0, 7)));
         endcase
         tx_idle = (phase != 6) && (phase != PHASES - 1);
         rx_idle = (phase != PHASES - 1);
         if (phase == 6) hold_req <= 1'b1;
         if (phase <= 3)
            for (i = 0; i < 4; i++) send_point(edge_points[i][0], edge_points[i][1]);
         send_random(PHASE_ITEMS);
      end
      drain();
      if (board.errors == 0)
         $display("fractal_value_noise_2d_top test passed");
      else
         $display("fractal_value_noise_2d_top test failed");
      $finish;
   end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/fvn2d_pkg.sv
hw/rtl/fvn2d_octave_cell.sv
hw/rtl/fvn2d_normaliser.sv
hw/rtl/fractal_value_noise_2d_top.sv
dv/testbench.sv
